// ===== hdl/drt_pkg.sv =====
// shared types and constants for the damage rectangle accumulator
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;

  localparam int unsigned MaxRectsDef = 16;
  localparam int unsigned CountW      = 7;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned BoxW        = 4 * CoordW;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOUND_X = 2'd0,
    CFG_BOUND_Y = 2'd1,
    CFG_BOUND_W = 2'd2,
    CFG_BOUND_H = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [CoordW-1:0] w;
    logic        [CoordW-1:0] h;
  } box_t;

  typedef struct packed {
    logic        [1:0]        action;
    logic signed [CoordW-1:0] rect_x;
    logic signed [CoordW-1:0] rect_y;
    logic        [CoordW-1:0] rect_w;
    logic        [CoordW-1:0] rect_h;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic        [CoordW-1:0] out_w;
    logic        [CoordW-1:0] out_h;
    logic                     is_full;
    logic                     is_empty;
    logic        [CountW-1:0] rect_count;
    logic                     last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_APP_WR,
    S_COLL_INIT,
    S_COLL_RD,
    S_COLL_EV,
    S_COLL_WR,
    S_RES_RD,
    S_RES_EV,
    S_TAIL_RD,
    S_TAIL_WR,
    S_FIN_WR,
    S_STAT,
    S_OUT_RD,
    S_OUT_EV
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MARK,
    OP_CLEAR,
    OP_RD_I,
    OP_NEXT_I,
    OP_HIT,
    OP_APPEND,
    OP_COLL_INIT,
    OP_RD_K,
    OP_COLL_JOIN,
    OP_COLL_WR,
    OP_RD_J,
    OP_NEXT_J,
    OP_ABSORB,
    OP_MOVE_IDX,
    OP_DROP,
    OP_RD_TAIL,
    OP_TAIL_WR,
    OP_FIN_WR,
    OP_EMIT_STAT,
    OP_EMIT_RD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    skip_add;
    logic    near_nb;
    logic    near_acc;
    logic    i_end;
    logic    k_end;
    logic    k_last;
    logic    j_end;
    logic    j_is_idx;
    logic    j_is_tail;
    logic    tail_is_idx;
    logic    table_full;
    logic    cnt_zero;
    logic    out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/drt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module drt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/drt_ctrl.sv =====
// sequencer for the damage rectangle accumulator
`timescale 1ns / 1ps
`default_nettype none
module drt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire drt_pkg::status_t st_i,
  output drt_pkg::cmd_t         cmd_o
);
  import drt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (st_i.act)
          ACT_ADD:  state_d = st_i.skip_add ? S_STAT : S_SCAN_RD;
          ACT_READ: state_d = st_i.cnt_zero ? S_STAT : S_OUT_RD;
          default:  state_d = S_STAT;
        endcase
      end
      S_SCAN_RD: begin
        if (!st_i.i_end)          state_d = S_SCAN_EV;
        else if (st_i.table_full) state_d = S_COLL_INIT;
        else                      state_d = S_APP_WR;
      end
      S_SCAN_EV:   state_d = st_i.near_nb ? S_RES_RD : S_SCAN_RD;
      S_APP_WR:    state_d = S_STAT;
      S_COLL_INIT: state_d = S_COLL_RD;
      S_COLL_RD:   state_d = st_i.k_end ? S_COLL_WR : S_COLL_EV;
      S_COLL_EV:   state_d = S_COLL_RD;
      S_COLL_WR:   state_d = S_STAT;
      S_RES_RD: begin
        if (st_i.j_end)         state_d = S_FIN_WR;
        else if (!st_i.j_is_idx) state_d = S_RES_EV;
      end
      S_RES_EV: state_d = st_i.near_acc ? S_TAIL_RD : S_RES_RD;
      S_TAIL_RD: begin
        if (st_i.tail_is_idx || st_i.j_is_tail) state_d = S_RES_RD;
        else                                    state_d = S_TAIL_WR;
      end
      S_TAIL_WR: state_d = S_RES_RD;
      S_FIN_WR:  state_d = S_STAT;
      S_STAT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      S_OUT_RD: state_d = S_OUT_EV;
      S_OUT_EV: begin
        if (st_i.out_free) state_d = st_i.k_last ? S_IDLE : S_OUT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DISPATCH: begin
        case (st_i.act)
          ACT_MARK:  cmd_o.op = OP_MARK;
          ACT_CLEAR: cmd_o.op = OP_CLEAR;
          default:   cmd_o.op = OP_NONE;
        endcase
      end
      S_SCAN_RD: begin
        if (!st_i.i_end) cmd_o.op = OP_RD_I;
      end
      S_SCAN_EV:   cmd_o.op = st_i.near_nb ? OP_HIT : OP_NEXT_I;
      S_APP_WR:    cmd_o.op = OP_APPEND;
      S_COLL_INIT: cmd_o.op = OP_COLL_INIT;
      S_COLL_RD: begin
        if (!st_i.k_end) cmd_o.op = OP_RD_K;
      end
      S_COLL_EV: cmd_o.op = OP_COLL_JOIN;
      S_COLL_WR: cmd_o.op = OP_COLL_WR;
      S_RES_RD: begin
        if (!st_i.j_end) cmd_o.op = st_i.j_is_idx ? OP_NEXT_J : OP_RD_J;
      end
      S_RES_EV: cmd_o.op = st_i.near_acc ? OP_ABSORB : OP_NEXT_J;
      S_TAIL_RD: begin
        if (st_i.tail_is_idx)    cmd_o.op = OP_MOVE_IDX;
        else if (st_i.j_is_tail) cmd_o.op = OP_DROP;
        else                     cmd_o.op = OP_RD_TAIL;
      end
      S_TAIL_WR: cmd_o.op = OP_TAIL_WR;
      S_FIN_WR:  cmd_o.op = OP_FIN_WR;
      S_STAT: begin
        if (st_i.out_free) cmd_o.op = OP_EMIT_STAT;
      end
      S_OUT_RD: cmd_o.op = OP_RD_K;
      S_OUT_EV: begin
        if (st_i.out_free) cmd_o.op = OP_EMIT_RD;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/drt_dp.sv =====
// datapath: bounds, rectangle store, merge arithmetic and output register
`timescale 1ns / 1ps
`default_nettype none
module drt_dp #(
  parameter int unsigned MAX_RECTS = drt_pkg::MaxRectsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [drt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [drt_pkg::CoordW-1:0]   cfg_data_i,
  input  wire drt_pkg::in_item_t            in_item_i,
  input  wire drt_pkg::cmd_t                cmd_i,
  output drt_pkg::status_t                  st_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output drt_pkg::out_item_t                out_item_o
);
  import drt_pkg::*;

  localparam int unsigned AddrW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam logic [CountW-1:0] MaxCnt = CountW'(MAX_RECTS);

  typedef logic signed [19:0] wide_t;

  function automatic wide_t sx(input logic signed [CoordW-1:0] v);
    return wide_t'(v);
  endfunction

  function automatic wide_t ux(input logic [CoordW-1:0] v);
    return wide_t'({4'b0000, v});
  endfunction

  function automatic logic [CoordW-1:0] sat16(input wide_t v);
    logic [CoordW-1:0] r;
    if (v < 0)              r = '0;
    else if (v > 20'sd65535) r = '1;
    else                    r = v[CoordW-1:0];
    return r;
  endfunction

  function automatic box_t clip_f(input box_t a, input box_t b);
    box_t  r;
    wide_t x0, y0, x1, y1, ax1, bx1, ay1, by1;
    r   = '0;
    x0  = (sx(a.x) > sx(b.x)) ? sx(a.x) : sx(b.x);
    y0  = (sx(a.y) > sx(b.y)) ? sx(a.y) : sx(b.y);
    ax1 = sx(a.x) + ux(a.w);
    bx1 = sx(b.x) + ux(b.w);
    ay1 = sx(a.y) + ux(a.h);
    by1 = sx(b.y) + ux(b.h);
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    if (x1 > x0 && y1 > y0) begin
      r.x = x0[CoordW-1:0];
      r.y = y0[CoordW-1:0];
      r.w = sat16(x1 - x0);
      r.h = sat16(y1 - y0);
    end
    return r;
  endfunction

  function automatic box_t join_f(input box_t a, input box_t b);
    box_t  r;
    wide_t rx, ry, x1, y1, ax1, bx1, ay1, by1;
    ax1 = sx(a.x) + ux(a.w);
    bx1 = sx(b.x) + ux(b.w);
    ay1 = sx(a.y) + ux(a.h);
    by1 = sx(b.y) + ux(b.h);
    rx  = (sx(a.x) < sx(b.x)) ? sx(a.x) : sx(b.x);
    ry  = (sx(a.y) < sx(b.y)) ? sx(a.y) : sx(b.y);
    x1  = (ax1 > bx1) ? ax1 : bx1;
    y1  = (ay1 > by1) ? ay1 : by1;
    r.x = rx[CoordW-1:0];
    r.y = ry[CoordW-1:0];
    r.w = sat16(x1 - rx);
    r.h = sat16(y1 - ry);
    if (a.w == '0 || a.h == '0) r = b;
    else if (b.w == '0 || b.h == '0) r = a;
    return r;
  endfunction

  function automatic logic near_f(input box_t a, input box_t b);
    return (sx(a.x) <= sx(b.x) + ux(b.w) + 20'sd2) &&
           (sx(b.x) <= sx(a.x) + ux(a.w) + 20'sd2) &&
           (sx(a.y) <= sx(b.y) + ux(b.h) + 20'sd2) &&
           (sx(b.y) <= sx(a.y) + ux(a.h) + 20'sd2);
  endfunction

  box_t              bound_q;
  box_t              nb_q, nb_d;
  box_t              acc_q, acc_d;
  action_e           act_q, act_d;
  logic              full_q, full_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              we, re;
  logic [AddrW-1:0]  waddr, raddr;
  box_t              wdata, rdata;
  logic [BoxW-1:0]   rdata_raw;
  logic [CountW-1:0] tail;
  box_t              in_box;

  assign rdata  = box_t'(rdata_raw);
  assign tail   = cnt_q - CountW'(1);
  assign in_box = '{x: in_item_i.rect_x, y: in_item_i.rect_y,
                    w: in_item_i.rect_w, h: in_item_i.rect_h};

  drt_ram #(
    .Width (BoxW),
    .Depth (MAX_RECTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BOUND_X: bound_q.x <= cfg_data_i;
        CFG_BOUND_Y: bound_q.y <= cfg_data_i;
        CFG_BOUND_W: bound_q.w <= cfg_data_i;
        CFG_BOUND_H: bound_q.h <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      full_q      <= full_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q  <= nb_d;
    acc_q <= acc_d;
    act_q <= act_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    idx_q <= idx_d;
    out_q <= out_d;
  end

  always_comb begin
    nb_d        = nb_q;
    acc_d       = acc_q;
    act_d       = act_q;
    full_d      = full_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = '0;
    wdata       = acc_q;
    re          = 1'b0;
    raddr       = '0;
    case (cmd_i.op)
      OP_LOAD: begin
        nb_d  = clip_f(in_box, bound_q);
        act_d = action_e'(in_item_i.action);
        i_d   = '0;
        k_d   = '0;
      end
      OP_MARK: begin
        full_d = 1'b1;
        cnt_d  = '0;
      end
      OP_CLEAR: begin
        full_d = 1'b0;
        cnt_d  = '0;
      end
      OP_RD_I: begin
        re    = 1'b1;
        raddr = i_q[AddrW-1:0];
      end
      OP_NEXT_I: i_d = i_q + CountW'(1);
      OP_HIT: begin
        acc_d = join_f(rdata, nb_q);
        idx_d = i_q;
        j_d   = '0;
      end
      OP_APPEND: begin
        we    = 1'b1;
        waddr = cnt_q[AddrW-1:0];
        wdata = nb_q;
        cnt_d = cnt_q + CountW'(1);
      end
      OP_COLL_INIT: begin
        acc_d = nb_q;
        k_d   = '0;
      end
      OP_RD_K: begin
        re    = 1'b1;
        raddr = k_q[AddrW-1:0];
      end
      OP_COLL_JOIN: begin
        acc_d = join_f(acc_q, rdata);
        k_d   = k_q + CountW'(1);
      end
      OP_COLL_WR: begin
        we    = 1'b1;
        waddr = '0;
        cnt_d = CountW'(1);
      end
      OP_RD_J: begin
        re    = 1'b1;
        raddr = j_q[AddrW-1:0];
      end
      OP_NEXT_J: j_d = j_q + CountW'(1);
      OP_ABSORB: acc_d = join_f(acc_q, rdata);
      OP_MOVE_IDX: begin
        idx_d = j_q;
        cnt_d = tail;
        j_d   = '0;
      end
      OP_DROP: begin
        cnt_d = tail;
        j_d   = '0;
      end
      OP_RD_TAIL: begin
        re    = 1'b1;
        raddr = tail[AddrW-1:0];
      end
      OP_TAIL_WR: begin
        we    = 1'b1;
        waddr = j_q[AddrW-1:0];
        wdata = rdata;
        cnt_d = tail;
        j_d   = '0;
      end
      OP_FIN_WR: begin
        we    = 1'b1;
        waddr = idx_q[AddrW-1:0];
      end
      OP_EMIT_STAT: begin
        out_valid_d      = 1'b1;
        out_d            = '0;
        out_d.is_full    = full_q;
        out_d.is_empty   = !full_q && (cnt_q == '0);
        out_d.rect_count = cnt_q;
        out_d.last       = 1'b1;
      end
      OP_EMIT_RD: begin
        out_valid_d      = 1'b1;
        out_d.out_x      = rdata.x;
        out_d.out_y      = rdata.y;
        out_d.out_w      = rdata.w;
        out_d.out_h      = rdata.h;
        out_d.is_full    = full_q;
        out_d.is_empty   = !full_q && (cnt_q == '0);
        out_d.rect_count = cnt_q;
        out_d.last       = (k_q + CountW'(1) == cnt_q);
        k_d              = k_q + CountW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.act         = act_q;
    st_o.skip_add    = full_q || nb_q.w == '0 || nb_q.h == '0;
    st_o.near_nb     = near_f(rdata, nb_q);
    st_o.near_acc    = near_f(acc_q, rdata);
    st_o.i_end       = (i_q >= cnt_q);
    st_o.k_end       = (k_q >= cnt_q);
    st_o.k_last      = (k_q + CountW'(1) == cnt_q);
    st_o.j_end       = (j_q >= cnt_q);
    st_o.j_is_idx    = (j_q == idx_q);
    st_o.j_is_tail   = (j_q == tail);
    st_o.tail_is_idx = (idx_q == tail);
    st_o.table_full  = (cnt_q >= MaxCnt);
    st_o.cnt_zero    = (cnt_q == '0);
    st_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== hdl/damage_rect_accumulator.sv =====
// top level of the damage rectangle accumulator
// Tracks up to MAX_RECTS damaged screen rectangles in a store with one write and one read port.
// Input channel in_valid_i/in_stall_o carries one item: an action (add,
// mark whole screen, clear, read out) and a rectangle for adds. Output
// channel out_valid_o/out_stall_i returns one status item per action, or
// one item per stored rectangle on a read, with last on the final one.
// Bounds are written through cfg_valid_i/cfg_ready_o, index 0..3 for
// x, y, w, h; write them only while the block is idle.
// One item is worked on at a time. An add is dropped when the whole-screen
// flag is set or the clipped rectangle is empty; otherwise it scans the
// store, and on a hit a merge rescan through the store's one read port
// absorbs the stored rectangles that come near the merged one.
// Reset empties the table, clears the whole-screen flag and zeroes the
// bounds. A stalled receiver holds the output register; the block waits
// with it and takes no new item until the current one is finished.
`timescale 1ns / 1ps
`default_nettype none
module damage_rect_accumulator #(
  parameter int unsigned MAX_RECTS = drt_pkg::MaxRectsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [drt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [drt_pkg::CoordW-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire drt_pkg::in_item_t           in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output drt_pkg::out_item_t               out_item_o
);
  import drt_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  drt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  drt_dp #(
    .MAX_RECTS (MAX_RECTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the damage rectangle accumulator
`timescale 1ns / 1ps
module tb_top;
  import drt_pkg::*;

  localparam int NumSlots = 16;
  localparam int CycleLimit = 3000000;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } rect_t;

  class damage_scoreboard;
    rect_t     slots[NumSlots];
    int        used;
    bit        whole_screen;
    int        bnd_x, bnd_y, bnd_w, bnd_h;
    out_item_t pending[$];
    int        errors;

    function new();
      used = 0;
      whole_screen = 0;
      bnd_x = 0;
      bnd_y = 0;
      bnd_w = 0;
      bnd_h = 0;
      errors = 0;
    endfunction

    function void set_bound(cfg_idx_e idx, logic [CoordW-1:0] val);
      case (idx)
        CFG_BOUND_X: bnd_x = int'($signed(val));
        CFG_BOUND_Y: bnd_y = int'($signed(val));
        CFG_BOUND_W: bnd_w = int'(val);
        default:     bnd_h = int'(val);
      endcase
    endfunction

    function int sat(int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
    endfunction

    function bit non_empty(rect_t a);
      return a.w != 0 && a.h != 0;
    endfunction

    function rect_t clip(rect_t a, rect_t b);
      rect_t r;
      int x0, y0, x1, y1;
      r = '{0, 0, 0, 0};
      x0 = a.x > b.x ? a.x : b.x;
      y0 = a.y > b.y ? a.y : b.y;
      x1 = (a.x + a.w) < (b.x + b.w) ? a.x + a.w : b.x + b.w;
      y1 = (a.y + a.h) < (b.y + b.h) ? a.y + a.h : b.y + b.h;
      if (x1 <= x0 || y1 <= y0) return r;
      r = '{x0, y0, sat(x1 - x0), sat(y1 - y0)};
      return r;
    endfunction

    function rect_t unite(rect_t a, rect_t b);
      rect_t r;
      int x1, y1;
      if (!non_empty(a)) return b;
      if (!non_empty(b)) return a;
      r.x = a.x < b.x ? a.x : b.x;
      r.y = a.y < b.y ? a.y : b.y;
      x1 = (a.x + a.w) > (b.x + b.w) ? a.x + a.w : b.x + b.w;
      y1 = (a.y + a.h) > (b.y + b.h) ? a.y + a.h : b.y + b.h;
      r.w = sat(x1 - r.x);
      r.h = sat(y1 - r.y);
      return r;
    endfunction

    function bit touches(rect_t a, rect_t b);
      return a.x <= b.x + b.w + 2 && b.x <= a.x + a.w + 2 &&
             a.y <= b.y + b.h + 2 && b.y <= a.y + a.h + 2;
    endfunction

    function void add_rect(rect_t nb);
      rect_t all;
      int i, j, tail;
      if (whole_screen) return;
      nb = clip(nb, '{bnd_x, bnd_y, bnd_w, bnd_h});
      if (!non_empty(nb)) return;
      for (i = 0; i < used; i++) begin
        if (touches(slots[i], nb)) begin
          slots[i] = unite(slots[i], nb);
          j = 0;
          while (j < used) begin
            if (j != i && touches(slots[i], slots[j])) begin
              slots[i] = unite(slots[i], slots[j]);
              tail = used - 1;
              slots[j] = slots[tail];
              if (i == tail) i = j;
              used--;
              j = 0;
            end else begin
              j++;
            end
          end
          return;
        end
      end
      if (used >= NumSlots) begin
        all = nb;
        for (int k = 0; k < used; k++) all = unite(all, slots[k]);
        slots[0] = all;
        used = 1;
        return;
      end
      slots[used] = nb;
      used++;
    endfunction

    function void push_status(rect_t b, bit fin);
      out_item_t o;
      o.out_x = b.x[15:0];
      o.out_y = b.y[15:0];
      o.out_w = b.w[15:0];
      o.out_h = b.h[15:0];
      o.is_full = whole_screen;
      o.is_empty = !whole_screen && used == 0;
      o.rect_count = used[CountW-1:0];
      o.last = fin;
      pending.push_back(o);
    endfunction

    function void note_input(in_item_t it);
      rect_t none;
      none = '{0, 0, 0, 0};
      case (action_e'(it.action))
        ACT_ADD: add_rect('{int'(it.rect_x), int'(it.rect_y), int'(it.rect_w), int'(it.rect_h)});
        ACT_MARK: begin
          whole_screen = 1;
          used = 0;
        end
        ACT_CLEAR: begin
          whole_screen = 0;
          used = 0;
        end
        default: begin
          if (used != 0) begin
            for (int k = 0; k < used; k++) push_status(slots[k], k == used - 1);
            return;
          end
        end
      endcase
      push_status(none, 1);
    endfunction

    function void cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t r);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("out_x", e.out_x, r.out_x);
      cmp("out_y", e.out_y, r.out_y);
      cmp("out_w", e.out_w, r.out_w);
      cmp("out_h", e.out_h, r.out_h);
      cmp("is_full", e.is_full, r.is_full);
      cmp("is_empty", e.is_empty, r.is_empty);
      cmp("rect_count", e.rect_count, r.rect_count);
      cmp("last", e.last, r.last);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CoordW-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;

  damage_scoreboard sb;
  int               idle_pct;
  int               stall_pct;
  int               cycles;

  damage_rect_accumulator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && in_valid && !in_stall) sb.note_input(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  task automatic write_bound(cfg_idx_e idx, logic [CoordW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_bound(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bounds(int bx, int by, int bw, int bh);
    write_bound(CFG_BOUND_X, bx[15:0]);
    write_bound(CFG_BOUND_Y, by[15:0]);
    write_bound(CFG_BOUND_W, bw[15:0]);
    write_bound(CFG_BOUND_H, bh[15:0]);
  endtask

  task automatic send(action_e act, int x = 0, int y = 0, int w = 0, int h = 0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{act, x[15:0], y[15:0], w[15:0], h[15:0]};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 72)
        send(ACT_ADD, sb.bnd_x + $urandom_range(sb.bnd_w + 20) - 10,
             sb.bnd_y + $urandom_range(sb.bnd_h + 20) - 10,
             $urandom_range(30), $urandom_range(30));
      else if (r < 84) send(ACT_READ);
      else if (r < 87) send(ACT_CLEAR);
      else if (r < 89) send(ACT_MARK);
      else
        send(action_e'($urandom_range(3)), $urandom(), $urandom(), $urandom(), $urandom());
    end
    drain();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bounds after reset
    send(ACT_ADD, 5, 5, 10, 10);
    send(ACT_READ);
    drain();
    set_bounds(0, 0, 100, 100);
    send(ACT_ADD, 10, 10, 5, 5);
    send(ACT_ADD, 17, 10, 3, 3);
    send(ACT_ADD, 20, 30, 2, 2);
    send(ACT_ADD, 50, 50, 10, 10);
    send(ACT_READ);
    send(ACT_ADD, 10, 14, 12, 20);
    send(ACT_ADD, 70, 70, 0, 5);
    send(ACT_ADD, 70, 70, 5, 0);
    send(ACT_READ);
    send(ACT_MARK);
    send(ACT_ADD, 1, 1, 4, 4);
    send(ACT_READ);
    send(ACT_CLEAR);
    send(ACT_READ);
    send(ACT_ADD, -32768, -32768, 65535, 65535);
    send(ACT_READ);
    drain();
    set_bounds(-32768, -32768, 65535, 65535);
    send(ACT_CLEAR);
    send(ACT_ADD, -32768, -32768, 65535, 65535);
    drain();
    // rectangle whose right edge lies past the largest signed coordinate
    set_bounds(0, 0, 65535, 65535);
    send(ACT_ADD, 32767, 0, 100, 10);
    send(ACT_READ);
    drain();
    set_bounds(32767, 32767, 65535, 65535);
    send(ACT_CLEAR);
    send(ACT_ADD, 32767, 32767, 65535, 65535);
    send(ACT_READ);
    drain();

    set_bounds(0, 0, 120, 90);
    random_phase(80);
    idle_pct = 79;
    set_bounds(-50, -40, 60, 70);
    random_phase(80);
    idle_pct = 0;
    stall_pct = 79;
    set_bounds(1000, -2000, 300, 200);
    random_phase(80);
    idle_pct = 16;
    stall_pct = 16;
    set_bounds(-32768, 32700, 150, 67);
    random_phase(80);

    if (sb.pending.size() != 0) begin
      $error("%0d expected result items never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== damage_rect_accumulator.f =====
hdl/drt_pkg.sv
hdl/drt_ram.sv
hdl/drt_ctrl.sv
hdl/drt_dp.sv
hdl/damage_rect_accumulator.sv
tb/tb_top.sv
